// ===== design/knt_pkg.sv =====
// Shared types, codes and keyword tables for the keyword and number tokenizer.
package knt_pkg;

  localparam int VALUE_BITS = 31;
  localparam int LINE_BITS  = 24;
  localparam int KW_COUNT   = 8;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]  LINE_MAX  = {LINE_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2,
    MODE_CMT  = 2'd3
  } mode_t;

  localparam logic [3:0] KIND_END     = 4'd0;
  localparam logic [3:0] KIND_LITERAL = 4'd1;
  localparam logic [3:0] KIND_CONST   = 4'd2;
  localparam logic [3:0] KIND_DIR     = 4'd3;
  localparam logic [3:0] KIND_KW_BASE = 4'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // Keywords are left aligned in eight characters; the padding is never compared
  // because a position at or past the keyword length clears its match bit.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "height  ", "width   ", "newplane", "update  ",
    "airport ", "line    ", "exit    ", "beacon  "
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd5, 4'd8, 4'd6, 4'd7, 4'd4, 4'd4, 4'd6
  };
  localparam logic [63:0] DIR_SET = "wedcxzaq";

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]            token_kind;
    logic [7:0]            char_value;
    logic [VALUE_BITS-1:0] const_value;
    logic [LINE_BITS-1:0]  line_number;
    logic                  last_of_run;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_dir(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (DIR_SET[i*8 +: 8] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // One letter at position len narrows the set of keywords still in play.
  function automatic logic [KW_COUNT-1:0] kw_feed(input logic [KW_COUNT-1:0] mask,
                                                  input logic [3:0] len,
                                                  input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    logic [5:0]          base;
    m    = mask;
    base = {~len[2:0], 3'b000};
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((len >= KW_LEN[k]) || (KW_TEXT[k][base +: 8] != c)) m[k] = 1'b0;
    end
    return m;
  endfunction

endpackage

// ===== design/keyword_number_tokenizer.sv =====
// Top level of the keyword and number tokenizer: input stage, lexer and result queue.
//
// Usage: one ASCII byte, or an end mark, enters per input transaction on
// in_valid / in_stall / in_item. Each byte yields zero, one or two tokens on
// out_valid / out_stall / out_item; last_of_run marks the final token of a byte.
// The end mark flushes any pending number or word, gives an end token, returns
// the lexer to idle and reloads the line counter from start_line.
// The user writes start_line through cfg_wr_en / cfg_wr_data while the block is idle;
// the block does not enforce this. A write also loads the line counter at once.
// A byte is held in the input register, lexed from there into the result queue,
// and its tokens are taken from the head of the queue.
// Throughput: one byte per cycle while in_stall is low. The lexer pushes into a
// four-entry result queue and runs while the queue holds at most two tokens, so a
// byte that gives two tokens can make the input stall when the output side drains
// one token per cycle.
// Reset (rst_n low, synchronous) empties the input stage and the queue, puts the
// lexer in idle and sets start_line and the line counter to 1.
// When the receiver stalls, the queue fills, the lexer holds the byte in its
// input register and in_stall rises; nothing is dropped.
module keyword_number_tokenizer
  import knt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tok_t                 out_item,
  input  logic                 cfg_wr_en,
  input  logic [LINE_BITS-1:0] cfg_wr_data
);

  // Input register.
  logic     in_vld_r;
  in_item_t in_r;
  logic     in_acc;
  logic     proc;

  // Lexer state.
  mode_t                 mode_r,  mode_nxt;
  logic [VALUE_BITS-1:0] acc_r,   acc_nxt;
  logic [7:0]            first_r, first_nxt;
  logic [3:0]            len_r,   len_nxt;
  logic [KW_COUNT-1:0]   mask_r,  mask_nxt;
  logic [LINE_BITS-1:0]  line_r,  line_nxt;
  logic [LINE_BITS-1:0]  start_r;

  // Result queue.
  tok_t       fifo_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] cnt_r;
  logic       pop;

  // Combinational lexer signals.
  tok_t                  toks [2];
  logic [1:0]            ntok;
  logic [7:0]            c;
  logic                  do_start;
  logic [VALUE_BITS+3:0] acc_ext, acc_sum;
  tok_t                  flush_tok;
  logic                  kw_hit;

  assign c        = in_r.in_byte;
  assign proc     = in_vld_r && (cnt_r <= 3'd2);
  assign in_stall = in_vld_r && (cnt_r > 3'd2);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = (cnt_r != 3'd0);
  assign out_item  = fifo_r[rptr_r];
  assign pop       = out_valid && !out_stall;

  // acc * 10 + digit as shift and add; saturation is a compare against the maximum.
  assign acc_ext = (VALUE_BITS+4)'(acc_r);
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + (VALUE_BITS+4)'(c[3:0]);

  // Token for a word that ends: the first whole-word keyword match wins, then a
  // lone direction letter, else the first character as a literal.
  always_comb begin
    flush_tok             = '0;
    flush_tok.line_number = line_r;
    kw_hit                = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (mask_r[k] && (len_r == KW_LEN[k])) begin
        kw_hit               = 1'b1;
        flush_tok.token_kind = KIND_KW_BASE + 4'(k);
      end
    end
    if (!kw_hit) begin
      flush_tok.char_value = first_r;
      if ((len_r == 4'd1) && is_dir(first_r)) begin
        flush_tok.token_kind = KIND_DIR;
      end else begin
        flush_tok.token_kind = KIND_LITERAL;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    mask_nxt  = mask_r;
    line_nxt  = line_r;
    toks[0]   = '0;
    toks[1]   = '0;
    ntok      = 2'd0;
    do_start  = 1'b0;

    if (in_r.end_of_input) begin
      if (mode_r == MODE_NUM) begin
        toks[ntok[0]]             = '0;
        toks[ntok[0]].token_kind  = KIND_CONST;
        toks[ntok[0]].const_value = acc_r;
        toks[ntok[0]].line_number = line_r;
        ntok                      = ntok + 2'd1;
      end else if (mode_r == MODE_WORD) begin
        toks[ntok[0]] = flush_tok;
        ntok          = ntok + 2'd1;
      end
      toks[ntok[0]]             = '0;
      toks[ntok[0]].token_kind  = KIND_END;
      toks[ntok[0]].line_number = line_r;
      ntok                      = ntok + 2'd1;
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      len_nxt  = 4'd0;
      mask_nxt = '1;
      line_nxt = start_r;
    end else begin
      case (mode_r)
        MODE_CMT: begin
          if (c == CH_LF) begin
            if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            if (acc_sum > (VALUE_BITS+4)'(VALUE_MAX)) begin
              acc_nxt = VALUE_MAX;
            end else begin
              acc_nxt = acc_sum[VALUE_BITS-1:0];
            end
          end else begin
            toks[ntok[0]]             = '0;
            toks[ntok[0]].token_kind  = KIND_CONST;
            toks[ntok[0]].const_value = acc_r;
            toks[ntok[0]].line_number = line_r;
            ntok                      = ntok + 2'd1;
            mode_nxt                  = MODE_IDLE;
            do_start                  = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_letter(c)) begin
            mask_nxt = kw_feed(mask_r, len_r, c);
            if (len_r < 4'd9) len_nxt = len_r + 4'd1;
          end else begin
            toks[ntok[0]] = flush_tok;
            ntok          = ntok + 2'd1;
            mode_nxt      = MODE_IDLE;
            do_start      = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      // The byte that ends a run is handled again as the start of a new one.
      if (do_start) begin
        if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)) begin
          mode_nxt = MODE_IDLE;
        end else if (c == CH_LF) begin
          if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
        end else if (c == CH_HASH) begin
          mode_nxt = MODE_CMT;
        end else if (is_digit(c)) begin
          mode_nxt = MODE_NUM;
          acc_nxt  = VALUE_BITS'(c[3:0]);
        end else if (is_letter(c)) begin
          mode_nxt  = MODE_WORD;
          first_nxt = c;
          len_nxt   = 4'd1;
          mask_nxt  = kw_feed('1, 4'd0, c);
        end else begin
          toks[ntok[0]]             = '0;
          toks[ntok[0]].token_kind  = KIND_LITERAL;
          toks[ntok[0]].char_value  = c;
          toks[ntok[0]].line_number = line_r;
          ntok                      = ntok + 2'd1;
        end
      end
    end

    if (ntok == 2'd1) toks[0].last_of_run = 1'b1;
    if (ntok == 2'd2) toks[1].last_of_run = 1'b1;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
    if (in_acc) in_r <= in_item;
  end

  // Lexer state register. A register write takes priority over the lexer for
  // the line counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      acc_r   <= '0;
      first_r <= '0;
      len_r   <= 4'd0;
      mask_r  <= '1;
      start_r <= LINE_BITS'(1);
      line_r  <= LINE_BITS'(1);
    end else begin
      if (proc) begin
        mode_r  <= mode_nxt;
        acc_r   <= acc_nxt;
        first_r <= first_nxt;
        len_r   <= len_nxt;
        mask_r  <= mask_nxt;
      end
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
        line_r  <= cfg_wr_data;
      end else if (proc) begin
        line_r  <= line_nxt;
      end
    end
  end

  // Result queue: up to two pushes and one pop per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      wptr_r <= proc ? (wptr_r + ntok) : wptr_r;
      rptr_r <= rptr_r + {1'b0, pop};
      cnt_r  <= cnt_r + (proc ? {1'b0, ntok} : 3'd0) - {2'b00, pop};
    end
    if (proc && (ntok != 2'd0)) fifo_r[wptr_r] <= toks[0];
    if (proc && (ntok == 2'd2)) fifo_r[wptr_r + 2'd1] <= toks[1];
  end

  // The queue never holds more than four tokens.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overfilled");

  // The pointer distance tracks the fill count.
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd4) || (2'(wptr_r - rptr_r) == cnt_r[1:0]))
    else $error("result queue pointers and count disagree");

  // An end mark leaves the lexer idle with the line counter reloaded.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_r.end_of_input && !cfg_wr_en |=> (mode_r == MODE_IDLE) && (line_r == start_r))
    else $error("end mark did not return the lexer to idle");

  // The word length saturates at nine.
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n) len_r <= 4'd9)
    else $error("word length beyond saturation");

  // A byte that lexes to two tokens needs queue room for both.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (cnt_r + {1'b0, ntok}) <= 3'd4)
    else $error("lexer pushed into a full queue");

endmodule
